@@ rtl/pcm_to_pwm_block_fifo_unit_macros.svh @@
// Assertion macros shared by the checker of the PCM to PWM block FIFO.
`ifndef PCM_TO_PWM_BLOCK_FIFO_UNIT_MACROS_SVH
`define PCM_TO_PWM_BLOCK_FIFO_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define P2PBF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define P2PBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/p2pbf_pkg.sv @@
// Types, constants and helper functions of the PCM to PWM block FIFO.
package p2pbf_pkg;

	localparam int BLOCK_WORDS = 128;
	localparam int RING_SLOTS = 128;
	localparam int PHYS_SLOTS = RING_SLOTS + 1;
	localparam int OFF_W = $clog2(BLOCK_WORDS);
	localparam int SLOT_W = $clog2(PHYS_SLOTS);
	localparam int CNT_W = $clog2(RING_SLOTS);
	localparam int ADDR_W = SLOT_W + OFF_W;
	localparam int RAM_DEPTH = PHYS_SLOTS * (2 ** OFF_W);

	localparam int QP_W = 2;
	localparam int Q_DEPTH = 2 ** QP_W;
	localparam int QC_W = QP_W + 1;

	localparam logic [6:0] PREBUF_RESET = 7'd64;
	localparam logic [6:0] FILL_TARGET_RESET = 7'd80;
	localparam logic [7:0] IDLE_WORD_RESET = 8'd128;
	localparam logic [6:0] READY_MAX = 7'd127;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_PULL  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		CFG_PREBUF      = 2'd0,
		CFG_FILL_TARGET = 2'd1,
		CFG_IDLE_WORD   = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic        use_ram;
		logic [7:0]  word;
		logic        is_sil;
		logic        is_end;
		logic        pub;
		logic        drop;
		logic [6:0]  ready;
		logic [6:0]  peak_ready;
		logic [31:0] underruns;
		logic [31:0] drops;
		logic        may_start;
		logic        wants_more;
	} front_rec_t;

	typedef struct packed {
		logic [7:0]  pwm_word;
		logic        word_is_silence;
		logic        block_end;
		logic        block_published;
		logic        block_dropped;
		logic [6:0]  ready_blocks;
		logic [6:0]  ready_high_water;
		logic [31:0] underrun_total;
		logic [31:0] drop_total;
		logic        may_start;
		logic        wants_more;
	} result_t;

	function automatic logic [6:0] ready_sat(input logic [CNT_W-1:0] n);
		if (int'(n) > int'(READY_MAX)) begin
			return READY_MAX;
		end
		return 7'(n);
	endfunction

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		if (s == SLOT_W'(PHYS_SLOTS - 1)) begin
			return '0;
		end
		return s + SLOT_W'(1);
	endfunction

endpackage

@@ rtl/pcm_to_pwm_block_fifo_unit.sv @@
// Top level of the PCM to PWM block FIFO.
// Usage:
// The input side is a queue: drive action and sample with push high; the word is
// taken at a rising edge where push is high and full is low. Action 0 stores a
// sample as a PWM duty word, action 1 pulls one duty word, action 2 clears the
// ring, the staging block and the block in play.
// The result side is a queue too: while empty is low the oldest result is on the
// result ports, and it is taken at a rising edge where pop is high.
// Every accepted word gives exactly one result. The accepted word is first held
// in a record register beside the registered RAM read data; the two are then
// joined and written into the result queue, from which it can be popped.
// Throughput is one word per cycle, set by the single RAM access that a push or a
// pull makes; full rises only when the four-entry result queue backs up.
// When pop stays low the results wait in the queue and full rises, so the
// producer stalls without loss. Reset empties the ring and the result queue,
// zeroes the counters and the high-water mark and loads the register defaults;
// no memory pass follows. Registers are written through cfg_we, cfg_index and
// cfg_data only while idle: the user's duty, as the block does not enforce it.
module pcm_to_pwm_block_fifo_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         action,
	input  logic signed [15:0] sample,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         pwm_word,
	output logic               word_is_silence,
	output logic               block_end,
	output logic               block_published,
	output logic               block_dropped,
	output logic [6:0]         ready_blocks,
	output logic [6:0]         ready_high_water,
	output logic [31:0]        underrun_total,
	output logic [31:0]        drop_total,
	output logic               may_start,
	output logic               wants_more,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	logic                  accept;
	p2pbf_pkg::ram_req_t   ram_req;
	logic [7:0]            ram_rdata;
	logic                  rec_valid_s1;
	p2pbf_pkg::front_rec_t rec_s1;
	p2pbf_pkg::result_t    head;

	assign accept = push && !full;

	p2pbf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.action       (action),
		.sample       (sample),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ram_req      (ram_req),
		.rec_valid_s1 (rec_valid_s1),
		.rec_s1       (rec_s1)
	);

	p2pbf_ram #(
		.WIDTH (8),
		.DEPTH (p2pbf_pkg::RAM_DEPTH)
	) u_ring_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	p2pbf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid_s1 (rec_valid_s1),
		.rec_s1       (rec_s1),
		.ram_rdata    (ram_rdata),
		.pop          (pop),
		.full         (full),
		.empty        (empty),
		.head         (head)
	);

	assign pwm_word = head.pwm_word;
	assign word_is_silence = head.word_is_silence;
	assign block_end = head.block_end;
	assign block_published = head.block_published;
	assign block_dropped = head.block_dropped;
	assign ready_blocks = head.ready_blocks;
	assign ready_high_water = head.ready_high_water;
	assign underrun_total = head.underrun_total;
	assign drop_total = head.drop_total;
	assign may_start = head.may_start;
	assign wants_more = head.wants_more;

endmodule

@@ rtl/p2pbf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module p2pbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/p2pbf_front.sv @@
// Front part: takes words, keeps ring and staging state, drives the RAM.
module p2pbf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [1:0]            action,
	input  logic signed [15:0]    sample,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [7:0]            cfg_data,
	output p2pbf_pkg::ram_req_t   ram_req,
	output logic                  rec_valid_s1,
	output p2pbf_pkg::front_rec_t rec_s1
);

	logic [p2pbf_pkg::OFF_W-1:0]  fill_q, fill_d;
	logic [p2pbf_pkg::OFF_W-1:0]  off_q, off_d;
	logic [p2pbf_pkg::SLOT_W-1:0] head_q, head_d;
	logic [p2pbf_pkg::SLOT_W-1:0] tail_q, tail_d;
	logic [p2pbf_pkg::SLOT_W-1:0] play_q, play_d;
	logic [p2pbf_pkg::CNT_W-1:0]  cnt_q, cnt_d;
	logic                         sil_q, sil_d;
	logic [6:0]                   hw_q, hw_d;
	logic [31:0]                  under_q, under_d;
	logic [31:0]                  drop_q, drop_d;
	logic [6:0]                   prebuf_q;
	logic [6:0]                   target_q;
	logic [7:0]                   idle_q;
	p2pbf_pkg::front_rec_t        rec_d;

	always_comb begin
		fill_d = fill_q;
		off_d = off_q;
		head_d = head_q;
		tail_d = tail_q;
		play_d = play_q;
		cnt_d = cnt_q;
		sil_d = sil_q;
		hw_d = hw_q;
		under_d = under_q;
		drop_d = drop_q;
		ram_req = '0;
		rec_d = '0;
		if (accept) begin
			case (p2pbf_pkg::action_t'(action))
				p2pbf_pkg::ACT_PUSH: begin
					ram_req.we = 1'b1;
					ram_req.waddr = {tail_q, fill_q};
					ram_req.wdata = {~sample[15], sample[14:8]};
					if (fill_q == p2pbf_pkg::OFF_W'(p2pbf_pkg::BLOCK_WORDS - 1)) begin
						fill_d = '0;
						if (cnt_q == p2pbf_pkg::CNT_W'(p2pbf_pkg::RING_SLOTS - 1)) begin
							drop_d = drop_q + 32'd1;
							rec_d.drop = 1'b1;
						end else begin
							tail_d = p2pbf_pkg::next_slot(tail_q);
							cnt_d = cnt_q + p2pbf_pkg::CNT_W'(1);
							rec_d.pub = 1'b1;
							if (p2pbf_pkg::ready_sat(cnt_d) > hw_q) begin
								hw_d = p2pbf_pkg::ready_sat(cnt_d);
							end
						end
					end else begin
						fill_d = fill_q + p2pbf_pkg::OFF_W'(1);
					end
				end
				p2pbf_pkg::ACT_PULL: begin
					if (off_q == '0) begin
						if (cnt_q == '0) begin
							sil_d = 1'b1;
							under_d = under_q + 32'd1;
						end else begin
							sil_d = 1'b0;
							play_d = head_q;
							head_d = p2pbf_pkg::next_slot(head_q);
							cnt_d = cnt_q - p2pbf_pkg::CNT_W'(1);
						end
					end
					if (sil_d) begin
						rec_d.word = idle_q;
						rec_d.is_sil = 1'b1;
					end else begin
						rec_d.use_ram = 1'b1;
						ram_req.re = 1'b1;
						ram_req.raddr = {play_d, off_q};
					end
					if (off_q == p2pbf_pkg::OFF_W'(p2pbf_pkg::BLOCK_WORDS - 1)) begin
						rec_d.is_end = 1'b1;
						off_d = '0;
					end else begin
						off_d = off_q + p2pbf_pkg::OFF_W'(1);
					end
				end
				p2pbf_pkg::ACT_CLEAR: begin
					head_d = '0;
					tail_d = '0;
					fill_d = '0;
					off_d = '0;
					sil_d = 1'b0;
					cnt_d = '0;
				end
				default: begin
				end
			endcase
		end
		rec_d.ready = p2pbf_pkg::ready_sat(cnt_d);
		rec_d.peak_ready = hw_d;
		rec_d.underruns = under_d;
		rec_d.drops = drop_d;
		rec_d.may_start = (rec_d.ready >= prebuf_q);
		rec_d.wants_more = (rec_d.ready < target_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			off_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			play_q <= '0;
			cnt_q <= '0;
			sil_q <= 1'b0;
			hw_q <= '0;
			under_q <= '0;
			drop_q <= '0;
			prebuf_q <= p2pbf_pkg::PREBUF_RESET;
			target_q <= p2pbf_pkg::FILL_TARGET_RESET;
			idle_q <= p2pbf_pkg::IDLE_WORD_RESET;
			rec_valid_s1 <= 1'b0;
		end else begin
			fill_q <= fill_d;
			off_q <= off_d;
			head_q <= head_d;
			tail_q <= tail_d;
			play_q <= play_d;
			cnt_q <= cnt_d;
			sil_q <= sil_d;
			hw_q <= hw_d;
			under_q <= under_d;
			drop_q <= drop_d;
			rec_valid_s1 <= accept;
			if (cfg_we) begin
				case (p2pbf_pkg::cfg_index_t'(cfg_index))
					p2pbf_pkg::CFG_PREBUF: begin
						prebuf_q <= cfg_data[6:0];
					end
					p2pbf_pkg::CFG_FILL_TARGET: begin
						target_q <= cfg_data[6:0];
					end
					p2pbf_pkg::CFG_IDLE_WORD: begin
						idle_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_s1 <= rec_d;
		end
	end

endmodule

@@ rtl/p2pbf_back.sv @@
// Back part: joins RAM read data to each record and queues the results.
module p2pbf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rec_valid_s1,
	input  p2pbf_pkg::front_rec_t rec_s1,
	input  logic [7:0]            ram_rdata,
	input  logic                  pop,
	output logic                  full,
	output logic                  empty,
	output p2pbf_pkg::result_t    head
);

	p2pbf_pkg::result_t          q_mem_q [p2pbf_pkg::Q_DEPTH];
	logic [p2pbf_pkg::QP_W-1:0]  wr_ptr_q;
	logic [p2pbf_pkg::QP_W-1:0]  rd_ptr_q;
	logic [p2pbf_pkg::QC_W-1:0]  count_q;
	p2pbf_pkg::result_t          res;
	logic                        deq;

	always_comb begin
		res.pwm_word = rec_s1.use_ram ? ram_rdata : rec_s1.word;
		res.word_is_silence = rec_s1.is_sil;
		res.block_end = rec_s1.is_end;
		res.block_published = rec_s1.pub;
		res.block_dropped = rec_s1.drop;
		res.ready_blocks = rec_s1.ready;
		res.ready_high_water = rec_s1.peak_ready;
		res.underrun_total = rec_s1.underruns;
		res.drop_total = rec_s1.drops;
		res.may_start = rec_s1.may_start;
		res.wants_more = rec_s1.wants_more;
	end

	assign empty = (count_q == '0);
	assign deq = pop && !empty;
	assign full = ((p2pbf_pkg::QC_W + 1)'(count_q) + (p2pbf_pkg::QC_W + 1)'(rec_valid_s1))
		>= (p2pbf_pkg::QC_W + 1)'(p2pbf_pkg::Q_DEPTH);
	assign head = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (rec_valid_s1) begin
				wr_ptr_q <= wr_ptr_q + p2pbf_pkg::QP_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + p2pbf_pkg::QP_W'(1);
			end
			if (rec_valid_s1 && !deq) begin
				count_q <= count_q + p2pbf_pkg::QC_W'(1);
			end else if (!rec_valid_s1 && deq) begin
				count_q <= count_q - p2pbf_pkg::QC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid_s1) begin
			q_mem_q[wr_ptr_q] <= res;
		end
	end

endmodule

@@ rtl/p2pbf_checker.sv @@
// Port-level checker of the PCM to PWM block FIFO and its bind statement.
`include "pcm_to_pwm_block_fifo_unit_macros.svh"

module p2pbf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [7:0]         pwm_word,
	input logic               word_is_silence,
	input logic               block_end,
	input logic               block_published,
	input logic               block_dropped,
	input logic [6:0]         ready_blocks,
	input logic [6:0]         ready_high_water,
	input logic [31:0]        underrun_total
);

	`P2PBF_ASSERT_SAME(a_pub_xor_drop, clk, arst_n, !empty && block_published, !block_dropped, "a word both published and dropped a block")

	`P2PBF_ASSERT_SAME(a_push_not_pull, clk, arst_n, !empty && (block_published || block_dropped), !block_end && !word_is_silence, "a push result carries pull flags")

	`P2PBF_ASSERT_SAME(a_high_water, clk, arst_n, !empty && block_published, ready_high_water >= ready_blocks, "high-water mark below ready count after publish")

	`P2PBF_ASSERT_NEXT(a_hold_result, clk, arst_n, !empty && !pop, !empty && $stable(pwm_word) && $stable(underrun_total), "stalled result word changed")

endmodule

bind pcm_to_pwm_block_fifo_unit p2pbf_checker u_checker (.*);

@@ sim/pcm_to_pwm_block_fifo_unit_checker.sv @@
// Checker that predicts every result word of the PCM to PWM block FIFO and compares it.
module pcm_to_pwm_block_fifo_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  action,
	input  logic [15:0] sample,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  pwm_word,
	input  logic        word_is_silence,
	input  logic        block_end,
	input  logic        block_published,
	input  logic        block_dropped,
	input  logic [6:0]  ready_blocks,
	input  logic [6:0]  ready_high_water,
	input  logic [31:0] underrun_total,
	input  logic [31:0] drop_total,
	input  logic        may_start,
	input  logic        wants_more,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          failures,
	output int          awaiting
);
	import p2pbf_pkg::*;

	logic [7:0]  ring_mem [RING_SLOTS * BLOCK_WORDS];
	logic [7:0]  stage_mem [BLOCK_WORDS];
	int unsigned stage_fill;
	int unsigned head;
	int unsigned tail;
	int unsigned rd_off;
	bit          in_silence;
	logic [6:0]  peak;
	logic [31:0] underruns;
	logic [31:0] drops;
	logic [6:0]  prebuf_reg;
	logic [6:0]  target_reg;
	logic [7:0]  idle_reg;
	result_t     outcome_q [$];
	result_t     want;
	result_t     fresh;
	int          errors;

	function automatic int unsigned ready_now();
		int unsigned n;
		n = (tail + RING_SLOTS - head) % RING_SLOTS;
		if (n > READY_MAX) begin
			return READY_MAX;
		end
		return n;
	endfunction

	task automatic step_model(input logic [1:0] act, input logic [15:0] smp,
			output result_t r);
		int unsigned nxt;
		int unsigned slot;
		int unsigned rdy;
		int          i;
		r = '0;
		case (act)
			ACT_PUSH: begin
				stage_mem[stage_fill] = {~smp[15], smp[14:8]};
				stage_fill++;
				if (stage_fill >= BLOCK_WORDS) begin
					nxt = (tail + 1) % RING_SLOTS;
					if (nxt != head) begin
						for (i = 0; i < BLOCK_WORDS; i++) begin
							ring_mem[tail * BLOCK_WORDS + i] = stage_mem[i];
						end
						tail = nxt;
						rdy = ready_now();
						if (rdy > peak) begin
							peak = 7'(rdy);
						end
						r.block_published = 1'b1;
					end else begin
						drops++;
						r.block_dropped = 1'b1;
					end
					stage_fill = 0;
				end
			end
			ACT_PULL: begin
				if (rd_off == 0) begin
					if (head == tail) begin
						in_silence = 1'b1;
						underruns++;
					end else begin
						in_silence = 1'b0;
						head = (head + 1) % RING_SLOTS;
					end
				end
				if (in_silence) begin
					r.pwm_word = idle_reg;
					r.word_is_silence = 1'b1;
				end else begin
					slot = (head + RING_SLOTS - 1) % RING_SLOTS;
					r.pwm_word = ring_mem[slot * BLOCK_WORDS + rd_off];
				end
				if (rd_off + 1 >= BLOCK_WORDS) begin
					r.block_end = 1'b1;
					rd_off = 0;
				end else begin
					rd_off++;
				end
			end
			ACT_CLEAR: begin
				head = 0;
				tail = 0;
				stage_fill = 0;
				rd_off = 0;
				in_silence = 1'b0;
			end
			default: begin
			end
		endcase
		rdy = ready_now();
		r.ready_blocks = 7'(rdy);
		r.ready_high_water = peak;
		r.underrun_total = underruns;
		r.drop_total = drops;
		r.may_start = (rdy >= prebuf_reg);
		r.wants_more = (rdy < target_reg);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_fill = 0;
			head = 0;
			tail = 0;
			rd_off = 0;
			in_silence = 1'b0;
			peak = '0;
			underruns = '0;
			drops = '0;
			prebuf_reg = PREBUF_RESET;
			target_reg = FILL_TARGET_RESET;
			idle_reg = IDLE_WORD_RESET;
			outcome_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PREBUF: prebuf_reg = cfg_data[6:0];
					CFG_FILL_TARGET: target_reg = cfg_data[6:0];
					CFG_IDLE_WORD: idle_reg = cfg_data;
					default: begin
					end
				endcase
			end
			if (pop && !empty) begin
				if (outcome_q.size() == 0) begin
					$error("result word arrived with nothing outstanding");
					errors++;
				end else begin
					want = outcome_q.pop_front();
					check_field("pwm_word", want.pwm_word, pwm_word);
					check_field("word_is_silence", want.word_is_silence, word_is_silence);
					check_field("block_end", want.block_end, block_end);
					check_field("block_published", want.block_published, block_published);
					check_field("block_dropped", want.block_dropped, block_dropped);
					check_field("ready_blocks", want.ready_blocks, ready_blocks);
					check_field("ready_high_water", want.ready_high_water, ready_high_water);
					check_field("underrun_total", want.underrun_total, underrun_total);
					check_field("drop_total", want.drop_total, drop_total);
					check_field("may_start", want.may_start, may_start);
					check_field("wants_more", want.wants_more, wants_more);
				end
			end
			if (push && !full) begin
				step_model(action, sample, fresh);
				outcome_q.push_back(fresh);
			end
		end
		failures <= errors;
		awaiting <= outcome_q.size();
	end

endmodule

@@ sim/pcm_to_pwm_block_fifo_unit_test.sv @@
// Testbench top of the PCM to PWM block FIFO: stimulus, idling and the final verdict.
module pcm_to_pwm_block_fifo_unit_test;
	import p2pbf_pkg::*;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int PHASE_WORDS = 120;
	localparam int HOLD_CYCLES = 400;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic [1:0]         action = ACT_PUSH;
	logic signed [15:0] sample = '0;
	logic               pop = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = CFG_PREBUF;
	logic [7:0]         cfg_data = '0;
	logic               full;
	logic               empty;
	logic [7:0]         pwm_word;
	logic               word_is_silence;
	logic               block_end;
	logic               block_published;
	logic               block_dropped;
	logic [6:0]         ready_blocks;
	logic [6:0]         ready_high_water;
	logic [31:0]        underrun_total;
	logic [31:0]        drop_total;
	logic               may_start;
	logic               wants_more;
	int                 failures;
	int                 awaiting;

	bit calm = 1'b0;
	bit sender_gaps = 1'b1;
	bit hold_off = 1'b0;
	int run_left = 0;

	pcm_to_pwm_block_fifo_unit dut (.*);

	pcm_to_pwm_block_fifo_unit_checker checker_i (.*);

	always #5 clk = ~clk;

	task automatic send_word(input logic [1:0] act, input logic [15:0] smp);
		logic stalled;
		push <= 1'b1;
		action <= act;
		sample <= smp;
		do begin
			@(negedge clk);
			stalled = (full !== 1'b0);
			@(posedge clk);
		end while (stalled);
		if (sender_gaps && !calm) begin
			if (run_left == 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				run_left = $urandom_range(1, 40);
			end else begin
				run_left--;
			end
		end
	endtask

	task automatic send_random(input int push_pct);
		int unsigned roll;
		logic [1:0]  act;
		logic [15:0] smp;
		roll = $urandom_range(999);
		if (roll < 6) begin
			act = ACT_SPARE;
		end else if (roll < 9) begin
			act = ACT_CLEAR;
		end else if (roll < 9 + 10 * push_pct) begin
			act = ACT_PUSH;
		end else begin
			act = ACT_PULL;
		end
		case ($urandom_range(15))
			0: smp = 16'h8000;
			1: smp = 16'h7fff;
			default: smp = 16'($urandom);
		endcase
		send_word(act, smp);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do begin
			@(negedge clk);
		end while (awaiting != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input logic [6:0] prebuf, input logic [6:0] target,
			input logic [7:0] idle);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= CFG_PREBUF;
		cfg_data <= {1'b0, prebuf};
		@(posedge clk);
		cfg_index <= CFG_FILL_TARGET;
		cfg_data <= {1'b0, target};
		@(posedge clk);
		cfg_index <= CFG_IDLE_WORD;
		cfg_data <= idle;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int run;
		run = 0;
		forever begin
			if (hold_off) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else if (!calm && run == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				run = $urandom_range(1, 40);
			end else begin
				pop <= 1'b1;
				if (run > 0) begin
					run--;
				end
				@(posedge clk);
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A silence block starts on an empty ring and picks up a new idle word mid-block.
		send_word(ACT_PULL, 16'h0000);
		write_regs(PREBUF_RESET, FILL_TARGET_RESET, 8'h00);
		send_word(ACT_PULL, 16'h1234);
		send_word(ACT_SPARE, 16'hffff);
		send_word(ACT_CLEAR, 16'h0000);
		send_word(ACT_PULL, 16'h8000);
		send_word(ACT_CLEAR, 16'h7fff);
		send_word(ACT_PUSH, 16'h8000);
		send_word(ACT_PUSH, 16'h7fff);
		send_word(ACT_PUSH, 16'h0000);
		send_word(ACT_PUSH, 16'hffff);
		send_word(ACT_PUSH, 16'h00ff);
		send_word(ACT_PUSH, 16'hff00);
		send_word(ACT_PUSH, 16'h5555);
		send_word(ACT_PUSH, 16'haaaa);
		send_word(ACT_PUSH, 16'h807f);
		send_word(ACT_PUSH, 16'h7f80);
		send_word(ACT_CLEAR, 16'h0000);
		send_word(ACT_SPARE, 16'h0000);

		write_regs(7'd0, 7'd0, 8'hff);
		repeat (PHASE_WORDS) send_random(60);
		write_regs(7'd127, 7'd127, 8'h00);
		repeat (PHASE_WORDS) send_random(30);
		write_regs(7'($urandom_range(3)), 7'($urandom_range(3)), 8'($urandom));
		repeat (PHASE_WORDS) send_random(55);
		write_regs(7'd1, 7'd2, 8'($urandom));
		repeat (PHASE_WORDS) send_random(50);

		// Hold off the receiver so two blocks' pushes stall, then play a block and a half.
		write_regs(7'd127, 7'd127, 8'($urandom));
		sender_gaps = 1'b0;
		send_word(ACT_CLEAR, 16'($urandom));
		hold_off = 1'b1;
		repeat (2 * BLOCK_WORDS) send_word(ACT_PUSH, 16'($urandom));
		repeat (BLOCK_WORDS + BLOCK_WORDS / 2) send_word(ACT_PULL, 16'($urandom));
		sender_gaps = 1'b1;

		write_regs(PREBUF_RESET, FILL_TARGET_RESET, IDLE_WORD_RESET);
		calm = 1'b1;
		send_word(ACT_CLEAR, 16'($urandom));
		repeat (120) send_random(55);

		wait_drained();
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#10000000;
		$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/p2pbf_pkg.sv
rtl/p2pbf_ram.sv
rtl/p2pbf_front.sv
rtl/p2pbf_back.sv
rtl/pcm_to_pwm_block_fifo_unit.sv
rtl/p2pbf_checker.sv
sim/pcm_to_pwm_block_fifo_unit_checker.sv
sim/pcm_to_pwm_block_fifo_unit_test.sv
